// ===== rtl/bssm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit-split string matcher package
// Shared widths, opcodes, item payloads and tile control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bssm_pkg;

    // Fixed geometry of the matcher
    localparam int TILES           = 4;
    localparam int PTR_W           = 8;
    localparam int PTR_CNT         = 4;
    localparam int SLICE_W         = 2;
    localparam int TILE_IDX_W      = 2;
    localparam int SYMBOL_W        = 8;
    localparam int MATCH_FIELD_W   = 24;

    // Defaults for the top-level parameters
    localparam int NODES_PER_TILE_DEF = 256;
    localparam int MATCH_WIDTH_DEF    = 24;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_SCAN  = 1'b1
    } t_opcode;

    // One input item
    typedef struct packed {
        t_opcode                    opcode;
        logic [TILE_IDX_W-1:0]      tile_index;
        logic [PTR_W-1:0]           node_address;
        logic [PTR_W-1:0]           next_ptr_0;
        logic [PTR_W-1:0]           next_ptr_1;
        logic [PTR_W-1:0]           next_ptr_2;
        logic [PTR_W-1:0]           next_ptr_3;
        logic [MATCH_FIELD_W-1:0]   match_bits;
        logic [SYMBOL_W-1:0]        symbol;
        logic                       packet_start;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [MATCH_FIELD_W-1:0]   match_vector;
    } t_out_item;

    // Scan control shared by all tiles
    typedef struct packed {
        logic rd_en;    // scan transfer: issue the node read
        logic sop;      // restart at node 0 before this symbol
        logic s1_vld;   // a read result sits in the second stage
        logic s1_adv;   // the second stage retires this cycle
    } t_tile_ctl;

    // Node write payload without the match vector
    typedef struct packed {
        logic [PTR_W-1:0]                addr;
        logic [PTR_CNT-1:0][PTR_W-1:0]   ptr;
    } t_node_wr;

endpackage

`default_nettype wire

// ===== rtl/bssm_if.sv =====
// ----------------------------------------------------------------------------
// Bit-split string matcher channels
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bssm_in_if import bssm_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bssm_out_if import bssm_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bssm_tile.sv =====
// ----------------------------------------------------------------------------
// Bit-split string matcher tile
// Node table memory of one tile, its current-node register and the
// next-node select that closes the per-symbol state loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bssm_tile import bssm_pkg::*; #(
    parameter int NODES   = NODES_PER_TILE_DEF,
    parameter int MATCH_W = MATCH_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_tile_ctl            i_ctl,
    input  wire logic [SLICE_W-1:0]   i_slice,
    input  wire logic                 i_wr_en,
    input  wire t_node_wr             i_wr,
    input  wire logic [MATCH_W-1:0]   i_wr_vec,
    output logic [MATCH_W-1:0]        o_vec
);

    localparam int AW     = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PTRS_W = PTR_CNT * PTR_W;
    localparam int WORD_W = PTRS_W + MATCH_W;

    logic [WORD_W-1:0]               mem [NODES];
    logic [WORD_W-1:0]               r_rd;
    logic [SLICE_W-1:0]              r_slice;
    logic                            r_oob;
    logic [PTR_W-1:0]                r_cur;

    logic [PTR_CNT-1:0][PTR_W-1:0]   rd_ptr;
    logic [PTR_W-1:0]                sel_ptr;
    logic [PTR_W-1:0]                cur_now;
    logic [PTR_W-1:0]                rd_node;
    logic                            rd_oob;
    logic                            wr_ok;

    // Select the next node from the registered read word
    always_comb begin
        rd_ptr  = r_rd[PTRS_W-1:0];
        sel_ptr = r_oob ? '0 : rd_ptr[r_slice];
        // Forward the pending step so the next symbol reads back to back
        cur_now = i_ctl.s1_vld ? sel_ptr : r_cur;
        rd_node = i_ctl.sop ? '0 : cur_now;
        rd_oob  = {1'b0, rd_node} >= (PTR_W+1)'(NODES);
        wr_ok   = i_wr_en && ({1'b0, i_wr.addr} < (PTR_W+1)'(NODES));
    end

    // Node table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[i_wr.addr[AW-1:0]] <= {i_wr_vec, i_wr.ptr};
        end
        if (i_ctl.rd_en) begin
            r_rd    <= mem[rd_node[AW-1:0]];
            r_slice <= i_slice;
            r_oob   <= rd_oob;
        end
    end

    // Advance the current node when the pending step retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (i_ctl.s1_vld && i_ctl.s1_adv) begin
            r_cur <= sel_ptr;
        end
    end

    // Drop the vector of an out-of-range node
    assign o_vec = r_oob ? '0 : r_rd[WORD_W-1 -: MATCH_W];

endmodule

`default_nettype wire

// ===== rtl/bit_split_string_matcher_core.sv =====
// ----------------------------------------------------------------------------
// Bit-split string matcher core
// Four-tile bit-split matcher: node writes and symbol scans on one input
// channel, nonzero ANDed match vectors on the result channel.
// ----------------------------------------------------------------------------
//  Channel   Dir  Modport  Transfer carries
//  i_scan    in   sink     opcode, tile/node write fields, symbol, packet_start
//  o_match   out  source   match_vector (nonzero only)
//
//  One item per cycle unless the input is held. A scan reads every tile
//  table into the read register at its transfer; a nonzero result is then
//  loaded into the output register. The selected pointer forwards straight
//  into the next read address, so scans run back to back. Reset clears the
//  current nodes and the valids; the node tables must be written first.
//  A stalled result holds input only once the read stage also holds a match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bit_split_string_matcher_core import bssm_pkg::*; #(
    parameter int NODES_PER_TILE = NODES_PER_TILE_DEF,
    parameter int MATCH_WIDTH    = MATCH_WIDTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bssm_in_if.sink     i_scan,
    bssm_out_if.source  o_match
);

    logic                        r_s1_vld;
    logic                        r_out_vld;
    t_out_item                   r_out;

    logic                        in_ready;
    logic                        in_xfer;
    logic                        scan_xfer;
    logic                        wr_xfer;
    logic                        s1_hit;
    logic                        s1_adv;
    t_tile_ctl                   tile_ctl;
    t_node_wr                    node_wr;
    logic [MATCH_WIDTH-1:0]      wr_vec;
    logic [MATCH_WIDTH-1:0]      tile_vec [TILES];
    logic [MATCH_WIDTH-1:0]      and_vec;
    logic [MATCH_FIELD_W-1:0]    match_vec;

    // Combine the tiles' vectors and decide whether the read stage retires
    always_comb begin
        and_vec = '1;
        for (int j = 0; j < TILES; j++) begin
            and_vec &= tile_vec[j];
        end
        match_vec = MATCH_FIELD_W'(and_vec);
        s1_hit    = |match_vec;
        s1_adv    = !r_out_vld || o_match.ready || !s1_hit;
        in_ready  = !r_s1_vld || s1_adv;
        in_xfer   = i_scan.valid && in_ready;
        scan_xfer = in_xfer && (i_scan.data.opcode == OP_SCAN);
        wr_xfer   = in_xfer && (i_scan.data.opcode == OP_WRITE);
    end

    // Build tile control and write payload
    always_comb begin
        tile_ctl.rd_en  = scan_xfer;
        tile_ctl.sop    = i_scan.data.packet_start;
        tile_ctl.s1_vld = r_s1_vld;
        tile_ctl.s1_adv = s1_adv;
        node_wr.addr    = i_scan.data.node_address;
        node_wr.ptr[0]  = i_scan.data.next_ptr_0;
        node_wr.ptr[1]  = i_scan.data.next_ptr_1;
        node_wr.ptr[2]  = i_scan.data.next_ptr_2;
        node_wr.ptr[3]  = i_scan.data.next_ptr_3;
        wr_vec          = MATCH_WIDTH'(i_scan.data.match_bits);
    end

    for (genvar j = 0; j < TILES; j++) begin : g_tile
        logic tile_wr;
        assign tile_wr = wr_xfer && (i_scan.data.tile_index == TILE_IDX_W'(j));

        bssm_tile #(
            .NODES   (NODES_PER_TILE),
            .MATCH_W (MATCH_WIDTH)
        ) u_tile (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (tile_ctl),
            .i_slice  (i_scan.data.symbol[SLICE_W*j +: SLICE_W]),
            .i_wr_en  (tile_wr),
            .i_wr     (node_wr),
            .i_wr_vec (wr_vec),
            .o_vec    (tile_vec[j])
        );
    end

    // Track the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (scan_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Load a nonzero result, hold it until the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_s1_vld && s1_adv && s1_hit) begin
            r_out_vld <= 1'b1;
        end else if (o_match.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s1_adv && s1_hit) begin
            r_out.match_vector <= match_vec;
        end
    end

    assign i_scan.ready  = in_ready;
    assign o_match.valid = r_out_vld;
    assign o_match.data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/bssm_checker.sv =====
// ----------------------------------------------------------------------------
// Bit-split string matcher checker
// Port-level assertions on the matcher core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bssm_checker import bssm_pkg::*; (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire t_opcode                    i_in_opcode,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [MATCH_FIELD_W-1:0]   i_out_vector
);

    logic scan_xfer;
    assign scan_xfer = i_in_valid && i_in_ready && (i_in_opcode == OP_SCAN);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_vector))
        else $error("stalled result changed");

    // Report only nonzero vectors
    a_out_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_vector != '0))
        else $error("zero match vector reported");

    // A fresh result follows an earlier scan transfer
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(scan_xfer, 2))
        else $error("result without a scan transfer");

    // Input waits only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind bit_split_string_matcher_core bssm_checker u_bssm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_scan.valid),
    .i_in_ready   (i_scan.ready),
    .i_in_opcode  (i_scan.data.opcode),
    .i_out_valid  (o_match.valid),
    .i_out_ready  (o_match.ready),
    .i_out_vector (o_match.data.match_vector)
);

`default_nettype wire

// ===== bench/bit_split_string_matcher_core_tb.sv =====
// ----------------------------------------------------------------------------
// Bit-split string matcher core testbench
// Builds node tables in all four tiles and scans packets of symbols through
// them. A scoreboard tracks the tables and the current node of each tile,
// predicts every nonzero ANDed match vector, and checks the results in order.
// Both channels idle at random, and one long hold-off on the result side
// fills the block until it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_split_string_matcher_core_tb import bssm_pkg::*;;

    localparam int NODES        = NODES_PER_TILE_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TIMEOUT_NS   = 2_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: tile tables, current nodes and the match vectors still due
    // ------------------------------------------------------------------------
    class match_vector_predictor;
        logic [PTR_W-1:0]         next_node [TILES][NODES][PTR_CNT];
        logic [MATCH_FIELD_W-1:0] node_match [TILES][NODES];
        logic [PTR_W-1:0]         cur_node [TILES];
        logic [MATCH_FIELD_W-1:0] due_vectors [$];
        int                       errors;

        function new();
            for (int t = 0; t < TILES; t++) begin
                cur_node[t] = '0;
                for (int a = 0; a < NODES; a++) begin
                    node_match[t][a] = '0;
                    for (int k = 0; k < PTR_CNT; k++)
                        next_node[t][a][k] = '0;
                end
            end
            errors = 0;
        endfunction

        // Apply one accepted input transfer to the tables or the tile walk
        function void note_item(t_in_item item);
            logic [MATCH_FIELD_W-1:0] acc;
            logic [SLICE_W-1:0]       slice;
            if (item.opcode == OP_WRITE) begin
                if (int'(item.node_address) < NODES) begin
                    next_node[item.tile_index][item.node_address][0] = item.next_ptr_0;
                    next_node[item.tile_index][item.node_address][1] = item.next_ptr_1;
                    next_node[item.tile_index][item.node_address][2] = item.next_ptr_2;
                    next_node[item.tile_index][item.node_address][3] = item.next_ptr_3;
                    node_match[item.tile_index][item.node_address] = item.match_bits;
                end
                return;
            end
            // Every tile reports the node it sits on, then steps on its slice
            acc = '1;
            for (int j = 0; j < TILES; j++) begin
                slice = item.symbol[SLICE_W*j +: SLICE_W];
                if (item.packet_start)
                    cur_node[j] = '0;
                acc &= node_match[j][cur_node[j]];
                cur_node[j] = next_node[j][cur_node[j]][slice];
            end
            if (acc != '0)
                due_vectors.push_back(acc);
        endfunction

        // Compare one result transfer with the oldest vector due
        function void check_match(t_out_item got);
            logic [MATCH_FIELD_W-1:0] want;
            if (due_vectors.size() == 0) begin
                $display("%0t: match_vector expected none, actual %h",
                         $time, got.match_vector);
                errors++;
                return;
            end
            want = due_vectors.pop_front();
            if (got.match_vector !== want) begin
                $display("%0t: match_vector expected %h, actual %h",
                         $time, want, got.match_vector);
                errors++;
            end
        endfunction

        function int pending();
            return due_vectors.size();
        endfunction

        // Flag vectors that never arrived
        function void close_out();
            if (due_vectors.size() != 0) begin
                $display("%0t: %0d match_vector results missing, expected %h first, actual none",
                         $time, due_vectors.size(), due_vectors[0]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bssm_in_if  scan_if ();
    bssm_out_if match_if ();

    bit_split_string_matcher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_match (match_if)
    );

    match_vector_predictor predictor;

    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          hold_req;
    int          items_sent;

    // Nodes written so far per tile; pointers only ever name these
    bit               node_written [TILES][NODES];
    logic [PTR_W-1:0] written_addrs [TILES][NODES];
    int               written_cnt [TILES] = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** bit_split_string_matcher_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Table bookkeeping and item builders
    // ------------------------------------------------------------------------
    function automatic void mark_written(int tile, logic [PTR_W-1:0] addr);
        if (!node_written[tile][addr]) begin
            node_written[tile][addr] = 1'b1;
            written_addrs[tile][written_cnt[tile]] = addr;
            written_cnt[tile]++;
        end
    endfunction

    function automatic logic [PTR_W-1:0] pick_written(int tile);
        return written_addrs[tile][$urandom_range(written_cnt[tile] - 1)];
    endfunction

    function automatic t_in_item node_item(int tile, logic [PTR_W-1:0] addr,
                                           logic [PTR_W-1:0] p0, logic [PTR_W-1:0] p1,
                                           logic [PTR_W-1:0] p2, logic [PTR_W-1:0] p3,
                                           logic [MATCH_FIELD_W-1:0] vec);
        t_in_item item;
        mark_written(tile, addr);
        item.opcode       = OP_WRITE;
        item.tile_index   = TILE_IDX_W'(tile);
        item.node_address = addr;
        item.next_ptr_0   = p0;
        item.next_ptr_1   = p1;
        item.next_ptr_2   = p2;
        item.next_ptr_3   = p3;
        item.match_bits   = vec;
        item.symbol       = SYMBOL_W'($urandom);
        item.packet_start = 1'($urandom_range(1));
        return item;
    endfunction

    function automatic t_in_item scan_item(logic [SYMBOL_W-1:0] sym, logic sop);
        t_in_item item;
        item.opcode       = OP_SCAN;
        item.tile_index   = TILE_IDX_W'($urandom);
        item.node_address = PTR_W'($urandom);
        item.next_ptr_0   = PTR_W'($urandom);
        item.next_ptr_1   = PTR_W'($urandom);
        item.next_ptr_2   = PTR_W'($urandom);
        item.next_ptr_3   = PTR_W'($urandom);
        item.match_bits   = MATCH_FIELD_W'($urandom);
        item.symbol       = sym;
        item.packet_start = sop;
        return item;
    endfunction

    // Mix dense, sparse and full vectors so ANDs land on both sides of zero
    function automatic logic [MATCH_FIELD_W-1:0] rand_match();
        logic [MATCH_FIELD_W-1:0] vec;
        case ($urandom_range(3))
            0:       vec = MATCH_FIELD_W'($urandom);
            1:       vec = MATCH_FIELD_W'($urandom | $urandom);
            2:       vec = MATCH_FIELD_W'($urandom & $urandom & $urandom);
            default: vec = '1;
        endcase
        return vec;
    endfunction

    function automatic t_in_item random_node();
        int               tile;
        logic [PTR_W-1:0] addr;
        tile = $urandom_range(TILES - 1);
        if ($urandom_range(9) < 3)
            addr = pick_written(tile);
        else
            addr = PTR_W'($urandom_range(NODES - 1));
        // Register the node first so it may point to itself
        mark_written(tile, addr);
        return node_item(tile, addr, pick_written(tile), pick_written(tile),
                         pick_written(tile), pick_written(tile), rand_match());
    endfunction

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < src_idle_pct) begin
            scan_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        scan_if.valid <= 1'b1;
        scan_if.data  <= item;
        @(posedge i_clk);
        while (!scan_if.ready)
            @(posedge i_clk);
        predictor.note_item(item);
        items_sent++;
    endtask

    // Hold the input until every predicted result has come back
    task automatic wait_drained();
        int guard;
        guard = 0;
        scan_if.valid <= 1'b0;
        @(posedge i_clk);
        while (predictor.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // One random burst: table updates, a packet, or stray scans
    task automatic send_random_burst();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 25) begin
            len = $urandom_range(1, 4);
            repeat (len) send_item(random_node());
        end else if (r < 90) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                send_item(scan_item(SYMBOL_W'($urandom), k == 0));
        end else begin
            send_item(scan_item(SYMBOL_W'($urandom), 1'($urandom_range(1))));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: check each transfer, stall at random or on a long hold
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        match_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (match_if.valid === 1'b1 && match_if.ready === 1'b1)
                predictor.check_match(match_if.data);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                match_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                match_if.ready <= 1'b0;
            end else begin
                match_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [MATCH_FIELD_W-1:0] far_match [TILES];
        logic [SYMBOL_W-1:0]      dir_sym [11];
        logic                     dir_sop [11];
        int                       target;

        far_match = '{24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'hFFFFFF};
        dir_sym   = '{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'hFF,
                      8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'hFF};
        dir_sop   = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                      1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

        predictor    = new();
        items_sent   = 0;
        hold_req     = 1'b0;
        src_idle_pct = 35;
        snk_idle_pct = 77;

        i_rst_n       <= 1'b0;
        scan_if.valid <= 1'b0;
        scan_if.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Root and far nodes in every tile; the far nodes AND to zero
        for (int t = 0; t < TILES; t++)
            send_item(node_item(t, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, far_match[t]));
        for (int t = 0; t < TILES; t++)
            send_item(node_item(t, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, '1));
        send_item(node_item(0, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, '0));

        // Walk between root and far nodes, with and without packet starts
        for (int i = 0; i < 11; i++)
            send_item(scan_item(dir_sym[i], dir_sop[i]));

        // Random traffic in three idling phases; hold the sink in the last one
        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    src_idle_pct = 35;
                    snk_idle_pct = 77;
                end
                1: begin
                    src_idle_pct = 77;
                    snk_idle_pct = 35;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    hold_req     = 1'b1;
                end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                send_random_burst();
        end

        // Drain, let the pipeline settle, then report
        wait_drained();
        repeat (20) @(posedge i_clk);
        predictor.close_out();
        if (predictor.errors == 0)
            $display("** bit_split_string_matcher_core: PASSED **");
        else
            $display("** bit_split_string_matcher_core: FAILED **");
        $finish;
    end

endmodule
